// ----- rtl/pipt_pkg.sv -----
// Package for the point-in-polygon test block.
// Holds the command and status codes and the control state type.
// No dependencies.
`default_nettype none

package pipt_pkg;

  // request command field
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_QUERY  = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  // result status field
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/point_in_polygon_test_top.sv -----
// Point-in-polygon test by even-odd ray casting over a stored vertex table.
// Depends on pipt_pkg for command and status codes and the state type.
// Vertex coordinates live in one synchronous memory with one write port and one read port.
`default_nettype none

// Each request is append vertex, test point or clear. Append, clear and the
// unused command code complete in idle; an append on a full table returns a
// result with status full. A test on a table of n vertices (n >= 1) reads
// the vertex memory one entry per cycle through its single read port, forms
// the closing edge back to vertex 0 from the stored first vertex, and lets a
// three-stage compare pipeline (setup, differences, products) drain before
// the answer is posted. A test on an empty table posts status empty through
// the finish state, and the block is ready again as that result is posted.
// One request is worked on at a time; a new request is
// taken while an earlier result still waits in the output register.
module point_in_polygon_test_top
  import pipt_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   in_command,
  input  wire  signed [COORD_WIDTH-1:0] in_coord_x,
  input  wire  signed [COORD_WIDTH-1:0] in_coord_y,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_inside_res,
  output logic [1:0]                   out_status
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              in_acc;
  logic              out_free;
  logic              tbl_full;
  logic              walk_last;
  logic              pipe_busy;

  // memory access
  logic [2*W-1:0]    vtx_mem [MAX_VERTICES];
  logic [2*W-1:0]    rd_data_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     rd_addr;

  // query point
  logic signed [W-1:0] px_r, py_r;

  // pending result
  logic              pend_inside_r;
  status_t           pend_status_r;
  logic              out_valid_r;
  logic              out_inside_r;
  status_t           out_status_r;

  // stage 1: vertex data from memory or the stored first vertex
  logic              s1_v_r, s1_first_r, s1_close_r;
  logic signed [W-1:0] first_x_r, first_y_r;
  logic signed [W-1:0] prev_x_r, prev_y_r;
  logic signed [W-1:0] cur_x, cur_y;

  // stage 1 edge setup
  logic              horiz, up, in_span, right_of, vert;
  logic signed [W-1:0] xl, yl, xu, yu, xmax;

  // stage 2: differences
  logic              s2_v_r, s2_hit_r, s2_vert_r;
  logic signed [DW-1:0] s2_a_r, s2_b_r, s2_c_r, s2_d_r;

  // stage 3: products
  logic              s3_v_r, s3_hit_r, s3_vert_r;
  logic signed [PW-1:0] s3_pl_r, s3_pr_r;
  logic              toggle;
  logic              parity_r;

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign tbl_full  = (count_r == CNT_MAX);
  assign walk_last = (cnt_r == count_r);
  assign pipe_busy = s1_v_r || s2_v_r || s3_v_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_APPEND && tbl_full) begin
            state_nxt = ST_FINISH;
          end else if (in_command == CMD_QUERY) begin
            state_nxt = (count_r == '0) ? ST_FINISH : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    rd_addr  = cnt_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_acc && (in_command == CMD_APPEND) && !tbl_full;
      end
      ST_WALK: begin
        mem_re = !walk_last;
      end
      ST_DRAIN, ST_FINISH: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      parity_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // vertex count
      if (mem_we) begin
        count_r <= count_r + 1'b1;
      end else if (in_acc && in_command == CMD_CLEAR) begin
        count_r <= '0;
      end
      // walk counter and stage 1 issue
      if (state_r == ST_IDLE) begin
        cnt_r <= '0;
      end else if (state_r == ST_WALK) begin
        cnt_r <= cnt_r + 1'b1;
      end
      s1_v_r <= (state_r == ST_WALK);
      s2_v_r <= s1_v_r && !s1_first_r;
      s3_v_r <= s2_v_r;
      // parity over the crossings
      if (in_acc) begin
        parity_r <= 1'b0;
      end else if (s3_v_r && toggle) begin
        parity_r <= ~parity_r;
      end
      // result register
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // vertex memory, write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vtx_mem[count_r[AW-1:0]] <= {in_coord_x, in_coord_y};
    end
    if (mem_re) begin
      rd_data_r <= vtx_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
    end
    // which stage 1 slot this cycle carries
    s1_first_r <= (state_r == ST_WALK) && (cnt_r == '0);
    s1_close_r <= (state_r == ST_WALK) && walk_last;
    // pending result
    if (state_r == ST_IDLE && in_acc) begin
      pend_inside_r <= 1'b0;
      pend_status_r <= (in_command == CMD_QUERY) ? STATUS_EMPTY : STATUS_FULL;
    end else if (state_r == ST_DRAIN && !pipe_busy) begin
      pend_inside_r <= parity_r;
      pend_status_r <= STATUS_OK;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_inside_r <= pend_inside_r;
      out_status_r <= pend_status_r;
    end
  end

  // stage 1: current vertex, closing edge reuses vertex 0
  assign cur_x = s1_close_r ? first_x_r : $signed(rd_data_r[2*W-1:W]);
  assign cur_y = s1_close_r ? first_y_r : $signed(rd_data_r[W-1:0]);

  // edge setup: orient so y rises, span and bounding checks
  always_comb begin
    horiz    = (prev_y_r == cur_y);
    up       = (prev_y_r < cur_y);
    xl       = up ? prev_x_r : cur_x;
    yl       = up ? prev_y_r : cur_y;
    xu       = up ? cur_x : prev_x_r;
    yu       = up ? cur_y : prev_y_r;
    xmax     = (prev_x_r > cur_x) ? prev_x_r : cur_x;
    in_span  = (py_r > yl) && (py_r <= yu);
    right_of = (px_r > xmax);
    vert     = (prev_x_r == cur_x);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
      if (s1_first_r) begin
        first_x_r <= cur_x;
        first_y_r <= cur_y;
      end
    end
    // stage 2: differences at one extra bit
    s2_hit_r  <= !horiz && in_span && !right_of;
    s2_vert_r <= vert;
    s2_a_r    <= DW'(px_r) - DW'(xl);
    s2_b_r    <= DW'(yu) - DW'(yl);
    s2_c_r    <= DW'(py_r) - DW'(yl);
    s2_d_r    <= DW'(xu) - DW'(xl);
    // stage 3: full-width signed products
    s3_hit_r  <= s2_hit_r;
    s3_vert_r <= s2_vert_r;
    s3_pl_r   <= PW'(s2_a_r) * PW'(s2_b_r);
    s3_pr_r   <= PW'(s2_c_r) * PW'(s2_d_r);
  end

  // point on or left of the crossing
  assign toggle = s3_hit_r && (s3_vert_r || (s3_pl_r <= s3_pr_r));

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_status     = out_status_r;

`ifndef ASSERT_OFF
  // reads stay below the stored vertex count
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (CNT_W'(rd_addr) < count_r))
    else $error("vertex read beyond stored count");

  // no request is taken while the compare pipeline holds work
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !pipe_busy)
    else $error("request accepted during polygon walk");

  // the vertex count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("vertex count exceeds capacity");

  // a result is posted only from the finish state
  a_post_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result posted outside finish state");
`endif

endmodule

`default_nettype wire
